@@ design/ltc_pkg.sv @@
// Shared types and constants for the looper transport controller.
`default_nettype none

package ltc_pkg;

  // Fixed field widths.
  localparam int CMD_W         = 3;
  localparam int MODE_W        = 2;
  localparam int NUM_SAMPLES_W = 14;
  localparam int LENGTH_W      = 24;

  // Default widths of position and normalized position.
  localparam int POS_BITS_DEF  = 24;
  localparam int FRAC_BITS_DEF = 16;

  // Transport modes.
  typedef enum logic [MODE_W-1:0] {
    MODE_STOPPED   = 2'd0,
    MODE_RECORDING = 2'd1,
    MODE_PLAYING   = 2'd2,
    MODE_OVERDUB   = 2'd3
  } mode_t;

  // Transport commands.
  typedef enum logic [CMD_W-1:0] {
    CMD_TICK         = 3'd0,
    CMD_START_RECORD = 3'd1,
    CMD_STOP_RECORD  = 3'd2,
    CMD_START_PLAY   = 3'd3,
    CMD_STOP_PLAY    = 3'd4,
    CMD_START_OVDB   = 3'd5,
    CMD_STOP_OVDB    = 3'd6,
    CMD_SET_LENGTH   = 3'd7
  } cmd_t;

endpackage

`default_nettype wire

@@ design/ltc_if.sv @@
// Valid/ready channel interfaces for the transport controller input and result words.
`default_nettype none

interface ltc_in_if;
  logic                               valid;
  logic                               ready;
  logic [ltc_pkg::CMD_W-1:0]          cmd;
  logic [ltc_pkg::NUM_SAMPLES_W-1:0]  num_samples;
  logic [ltc_pkg::LENGTH_W-1:0]       length_value;

  modport source (output valid, cmd, num_samples, length_value, input ready);
  modport sink   (input valid, cmd, num_samples, length_value, output ready);
endinterface

interface ltc_out_if #(
  parameter int POS_BITS  = ltc_pkg::POS_BITS_DEF,
  parameter int FRAC_BITS = ltc_pkg::FRAC_BITS_DEF
);
  logic                        valid;
  logic                        ready;
  logic [ltc_pkg::MODE_W-1:0]  mode;
  logic [POS_BITS-1:0]         position;
  logic [POS_BITS-1:0]         loop_length;
  logic [FRAC_BITS-1:0]        normalized_position;

  modport source (output valid, mode, position, loop_length, normalized_position,
                  input ready);
  modport sink   (input valid, mode, position, loop_length, normalized_position,
                  output ready);
endinterface

`default_nettype wire

@@ design/looper_transport_controller_core.sv @@
// A command word goes straight to the posting state; a tick word in a running mode first runs
// the wrap division (when looping with a nonzero length), the fraction check and the fraction
// division. One word at a time, the next taken the cycle after the result posts; the bit-serial
// remainder/quotient unit sets the time, and a result the sink has not taken holds the block
// until it is.
// Reset (rst_n, synchronous, active low) clears mode, position, length, fraction and output valid.
`default_nettype none

module looper_transport_controller_core #(
  parameter int POS_BITS  = ltc_pkg::POS_BITS_DEF,
  parameter int FRAC_BITS = ltc_pkg::FRAC_BITS_DEF
) (
  input  wire       clk,
  input  wire       rst_n,
  ltc_in_if.sink    in_ch,
  ltc_out_if.source out_ch
);

  localparam int LW    = (POS_BITS > ltc_pkg::LENGTH_W) ? POS_BITS : ltc_pkg::LENGTH_W;
  localparam int STEPS = ((POS_BITS + 1) > FRAC_BITS) ? (POS_BITS + 1) : FRAC_BITS;
  localparam int CW    = $clog2(STEPS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOD,
    S_FCHK,
    S_FRAC,
    S_DONE
  } state_t;

  state_t                 state_r,  state_nxt;
  ltc_pkg::mode_t         mode_r,   mode_nxt;
  logic [POS_BITS-1:0]    pos_r,    pos_nxt;
  logic [POS_BITS-1:0]    len_r,    len_nxt;
  logic [FRAC_BITS-1:0]   frac_r,   frac_nxt;
  logic [POS_BITS-1:0]    rem_r,    rem_nxt;
  logic [POS_BITS:0]      dvd_r,    dvd_nxt;
  logic [FRAC_BITS-1:0]   q_r,      q_nxt;
  logic [CW-1:0]          cnt_r,    cnt_nxt;
  logic                   outv_r,   outv_nxt;
  logic [ltc_pkg::MODE_W-1:0] out_mode_r, out_mode_nxt;
  logic [POS_BITS-1:0]    out_pos_r,  out_pos_nxt;
  logic [POS_BITS-1:0]    out_len_r,  out_len_nxt;
  logic [FRAC_BITS-1:0]   out_frac_r, out_frac_nxt;

  logic                   in_acc;
  logic                   shift_bit;
  logic [POS_BITS:0]      rem_sh;
  logic [POS_BITS:0]      rem_sub;
  logic                   rem_ge;
  logic [POS_BITS-1:0]    rem_new;
  logic [POS_BITS:0]      tick_sum;
  logic [LW-1:0]          len_in_ext;
  logic [LW-1:0]          len_cap;
  logic [LW-1:0]          len_sat;
  logic                   looping;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;

  // One restoring step of the shared bit-serial divider.
  assign shift_bit = (state_r == S_MOD) ? dvd_r[POS_BITS] : 1'b0;
  assign rem_sh    = {rem_r, shift_bit};
  assign rem_ge    = (rem_sh >= {1'b0, len_r});
  assign rem_sub   = rem_sh - {1'b0, len_r};
  assign rem_new   = rem_ge ? rem_sub[POS_BITS-1:0] : rem_sh[POS_BITS-1:0];

  // Tick sum and saturated loop length for the set length command.
  assign tick_sum   = {1'b0, pos_r} + (POS_BITS + 1)'(in_ch.num_samples);
  assign len_in_ext = LW'(in_ch.length_value);
  assign len_cap    = LW'({POS_BITS{1'b1}});
  assign len_sat    = (len_in_ext > len_cap) ? len_cap : len_in_ext;
  assign looping    = (mode_r == ltc_pkg::MODE_PLAYING) || (mode_r == ltc_pkg::MODE_OVERDUB);

  // Sequencer: decode a word, run the wrap and fraction divisions, post the result.
  always_comb begin
    state_nxt    = state_r;
    mode_nxt     = mode_r;
    pos_nxt      = pos_r;
    len_nxt      = len_r;
    frac_nxt     = frac_r;
    rem_nxt      = rem_r;
    dvd_nxt      = dvd_r;
    q_nxt        = q_r;
    cnt_nxt      = cnt_r;
    outv_nxt     = outv_r;
    out_mode_nxt = out_mode_r;
    out_pos_nxt  = out_pos_r;
    out_len_nxt  = out_len_r;
    out_frac_nxt = out_frac_r;

    if (outv_r && out_ch.ready) begin
      outv_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_DONE;
          case (ltc_pkg::cmd_t'(in_ch.cmd))
            ltc_pkg::CMD_TICK: begin
              if (mode_r != ltc_pkg::MODE_STOPPED) begin
                if (looping && (len_r != '0)) begin
                  dvd_nxt   = tick_sum;
                  rem_nxt   = '0;
                  cnt_nxt   = CW'(POS_BITS + 1);
                  state_nxt = S_MOD;
                end else begin
                  pos_nxt   = tick_sum[POS_BITS] ? {POS_BITS{1'b1}} : tick_sum[POS_BITS-1:0];
                  state_nxt = S_FCHK;
                end
              end
            end
            ltc_pkg::CMD_START_RECORD: begin
              len_nxt  = '0;
              pos_nxt  = '0;
              frac_nxt = '0;
              mode_nxt = ltc_pkg::MODE_RECORDING;
            end
            ltc_pkg::CMD_STOP_RECORD: begin
              if (mode_r == ltc_pkg::MODE_RECORDING) begin
                if (pos_r != '0) begin
                  len_nxt  = pos_r;
                  pos_nxt  = '0;
                  frac_nxt = '0;
                  mode_nxt = ltc_pkg::MODE_PLAYING;
                end else begin
                  mode_nxt = ltc_pkg::MODE_STOPPED;
                end
              end
            end
            ltc_pkg::CMD_START_PLAY: begin
              if (len_r != '0) begin
                mode_nxt = ltc_pkg::MODE_PLAYING;
              end
            end
            ltc_pkg::CMD_STOP_PLAY: begin
              pos_nxt  = '0;
              frac_nxt = '0;
              mode_nxt = ltc_pkg::MODE_STOPPED;
            end
            ltc_pkg::CMD_START_OVDB: begin
              if (len_r != '0) begin
                mode_nxt = ltc_pkg::MODE_OVERDUB;
              end
            end
            ltc_pkg::CMD_STOP_OVDB: begin
              if (mode_r == ltc_pkg::MODE_OVERDUB) begin
                mode_nxt = ltc_pkg::MODE_PLAYING;
              end
            end
            ltc_pkg::CMD_SET_LENGTH: begin
              len_nxt = len_sat[POS_BITS-1:0];
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      // Remainder of the tick sum by the loop length, one dividend bit per cycle.
      S_MOD: begin
        rem_nxt = rem_new;
        dvd_nxt = {dvd_r[POS_BITS-1:0], 1'b0};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          pos_nxt   = rem_new;
          state_nxt = S_FCHK;
        end
      end

      // Zero length and position at or past the length need no division.
      S_FCHK: begin
        if (len_r == '0) begin
          frac_nxt  = '0;
          state_nxt = S_DONE;
        end else if (pos_r >= len_r) begin
          frac_nxt  = {FRAC_BITS{1'b1}};
          state_nxt = S_DONE;
        end else begin
          rem_nxt   = pos_r;
          cnt_nxt   = CW'(FRAC_BITS);
          state_nxt = S_FRAC;
        end
      end

      // Fractional long division, one quotient bit per cycle.
      S_FRAC: begin
        rem_nxt = rem_new;
        q_nxt   = {q_r[FRAC_BITS-2:0], rem_ge};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          frac_nxt  = {q_r[FRAC_BITS-2:0], rem_ge};
          state_nxt = S_DONE;
        end
      end

      // Post the result word once the result register is free.
      S_DONE: begin
        if (!outv_r || out_ch.ready) begin
          outv_nxt     = 1'b1;
          out_mode_nxt = mode_r;
          out_pos_nxt  = pos_r;
          out_len_nxt  = len_r;
          out_frac_nxt = frac_r;
          state_nxt    = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      mode_r  <= ltc_pkg::MODE_STOPPED;
      pos_r   <= '0;
      len_r   <= '0;
      frac_r  <= '0;
      cnt_r   <= '0;
      outv_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      mode_r  <= mode_nxt;
      pos_r   <= pos_nxt;
      len_r   <= len_nxt;
      frac_r  <= frac_nxt;
      cnt_r   <= cnt_nxt;
      outv_r  <= outv_nxt;
    end
    rem_r      <= rem_nxt;
    dvd_r      <= dvd_nxt;
    q_r        <= q_nxt;
    out_mode_r <= out_mode_nxt;
    out_pos_r  <= out_pos_nxt;
    out_len_r  <= out_len_nxt;
    out_frac_r <= out_frac_nxt;
  end

  assign out_ch.valid               = outv_r;
  assign out_ch.mode                = out_mode_r;
  assign out_ch.position            = out_pos_r;
  assign out_ch.loop_length         = out_len_r;
  assign out_ch.normalized_position = out_frac_r;

`ifndef NO_ASSERTIONS
  // The partial remainder always stays below the loop length while dividing.
  a_rem_below_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MOD || state_r == S_FRAC) |-> (rem_r < len_r))
    else $error("divider remainder reached the loop length");

  // The step counter never runs out inside a division.
  a_cnt_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MOD || state_r == S_FRAC) |-> (cnt_r != '0))
    else $error("divider step counter empty while dividing");

  // A new result word only appears from the posting state.
  a_post_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    (outv_r && !$past(outv_r) && $past(rst_n)) |-> $past(state_r == S_DONE))
    else $error("result word posted outside the posting state");

  // No word is accepted while a division is running.
  a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MOD || state_r == S_FRAC || state_r == S_FCHK) |-> !in_ch.ready)
    else $error("input accepted while busy");
`endif

endmodule

`default_nettype wire

@@ tb/tb_looper_transport_controller_core.sv @@
// Self-checking testbench for the looper transport controller core.
`default_nettype none

module tb_looper_transport_controller_core;
  timeunit 1ns;
  timeprecision 1ps;

  import ltc_pkg::*;

  localparam int POS_W         = POS_BITS_DEF;
  localparam int FRAC_W        = FRAC_BITS_DEF;
  localparam logic [63:0] POS_MAX  = (64'd1 << POS_W) - 64'd1;
  localparam logic [63:0] FRAC_MAX = (64'd1 << FRAC_W) - 64'd1;
  localparam int N_DIRECTED    = 27;
  localparam int N_RANDOM      = 1650;
  localparam int IDLE_LIMIT    = 4000;
  localparam int DRAIN_CYCLES  = 100;

  // One transport report as the block returns it.
  typedef struct packed {
    mode_t               mode;
    logic [POS_W-1:0]    position;
    logic [POS_W-1:0]    loop_length;
    logic [FRAC_W-1:0]   fraction;
  } report_t;

  // One input word, with an optional report typed in by hand.
  typedef struct packed {
    cmd_t                      cmd;
    logic [NUM_SAMPLES_W-1:0]  num_samples;
    logic [LENGTH_W-1:0]       length_value;
    logic                      known;
    report_t                   known_report;
  } word_t;

  logic clk;
  logic rst_n;

  ltc_in_if  in_ch ();
  ltc_out_if out_ch ();

  looper_transport_controller_core i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Words still to be sent and reports still to come back.
  word_t   pending_words[$];
  report_t expected_reports[$];
  word_t   dir_rows [N_DIRECTED];

  // Transport state as the testbench tracks it.
  mode_t              trk_mode;
  logic [POS_W-1:0]   trk_pos;
  logic [POS_W-1:0]   trk_len;
  logic [FRAC_W-1:0]  trk_frac;

  // Sender, receiver and checker bookkeeping.
  word_t   bus_word;
  report_t got_report;
  report_t want_report;
  logic    word_fire;
  logic    report_fire;
  int      burst_left;
  int      gap_left;
  int      rx_phase;
  int      rx_style;
  logic    rx_ready;
  int      n_fail;
  int      n_reports;
  int      idle_cycles;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Advance the tracked transport by one word and return the report it gives.
  function automatic report_t transport_step(word_t w);
    logic [63:0] sum;
    logic [63:0] quot;
    report_t     r;
    case (w.cmd)
      CMD_TICK: begin
        if (trk_mode != MODE_STOPPED) begin
          sum = 64'(trk_pos) + 64'(w.num_samples);
          if ((trk_mode == MODE_PLAYING || trk_mode == MODE_OVERDUB) && trk_len != '0) begin
            sum = sum % 64'(trk_len);
          end else if (sum > POS_MAX) begin
            sum = POS_MAX;
          end
          trk_pos = sum[POS_W-1:0];
          if (trk_len != '0) begin
            quot = (64'(trk_pos) << FRAC_W) / 64'(trk_len);
            trk_frac = (quot > FRAC_MAX) ? FRAC_MAX[FRAC_W-1:0] : quot[FRAC_W-1:0];
          end else begin
            trk_frac = '0;
          end
        end
      end
      CMD_START_RECORD: begin
        trk_len  = '0;
        trk_pos  = '0;
        trk_frac = '0;
        trk_mode = MODE_RECORDING;
      end
      CMD_STOP_RECORD: begin
        if (trk_mode == MODE_RECORDING) begin
          if (trk_pos != '0) begin
            trk_len  = trk_pos;
            trk_pos  = '0;
            trk_frac = '0;
            trk_mode = MODE_PLAYING;
          end else begin
            trk_mode = MODE_STOPPED;
          end
        end
      end
      CMD_START_PLAY: begin
        if (trk_len != '0) trk_mode = MODE_PLAYING;
      end
      CMD_STOP_PLAY: begin
        trk_pos  = '0;
        trk_frac = '0;
        trk_mode = MODE_STOPPED;
      end
      CMD_START_OVDB: begin
        if (trk_len != '0) trk_mode = MODE_OVERDUB;
      end
      CMD_STOP_OVDB: begin
        if (trk_mode == MODE_OVERDUB) trk_mode = MODE_PLAYING;
      end
      default: begin
        trk_len = (64'(w.length_value) > POS_MAX) ? POS_MAX[POS_W-1:0] : w.length_value;
      end
    endcase
    r.mode        = trk_mode;
    r.position    = trk_pos;
    r.loop_length = trk_len;
    r.fraction    = trk_frac;
    return r;
  endfunction

  function automatic word_t word_of(cmd_t c, logic [NUM_SAMPLES_W-1:0] n,
                                    logic [LENGTH_W-1:0] l);
    word_t w;
    w = '0;
    w.cmd          = c;
    w.num_samples  = n;
    w.length_value = l;
    return w;
  endfunction

  // Sample counts: mostly legal block sizes, sometimes the full field.
  function automatic logic [NUM_SAMPLES_W-1:0] pick_samples();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return NUM_SAMPLES_W'($urandom_range(8192, 16383));
      2:       return NUM_SAMPLES_W'(8192);
      default: return NUM_SAMPLES_W'($urandom_range(1, 8191));
    endcase
  endfunction

  // Loop lengths from tiny to the full field, zero included.
  function automatic logic [LENGTH_W-1:0] pick_length();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2, 3:    return LENGTH_W'($urandom_range(1, 64));
      4, 5:    return LENGTH_W'($urandom_range(65, 40000));
      default: return LENGTH_W'($urandom());
    endcase
  endfunction

  // Unused fields carry random bits so that the block must ignore them.
  function automatic void add_cmd(cmd_t c);
    pending_words.push_back(word_of(c, NUM_SAMPLES_W'($urandom()), LENGTH_W'($urandom())));
  endfunction

  function automatic void add_tick();
    pending_words.push_back(word_of(CMD_TICK, pick_samples(), LENGTH_W'($urandom())));
  endfunction

  function automatic void add_set_length();
    pending_words.push_back(word_of(CMD_SET_LENGTH, NUM_SAMPLES_W'($urandom()),
                                    pick_length()));
  endfunction

  // A record, play and overdub session with random content.
  function automatic void add_session();
    int n_rec;
    int n_play;
    add_cmd(CMD_START_RECORD);
    n_rec = $urandom_range(0, 10);
    repeat (n_rec) add_tick();
    if ($urandom_range(0, 5) == 0) begin
      add_set_length();
      add_tick();
    end
    if ($urandom_range(0, 7) == 0) add_cmd(CMD_START_PLAY);
    add_cmd(CMD_STOP_RECORD);
    n_play = $urandom_range(1, 24);
    repeat (n_play) begin
      case ($urandom_range(0, 15))
        0:       add_cmd(CMD_START_OVDB);
        1:       add_cmd(CMD_STOP_OVDB);
        2:       add_set_length();
        3:       add_cmd(CMD_START_PLAY);
        4:       add_cmd(cmd_t'($urandom_range(0, 7)));
        default: add_tick();
      endcase
    end
    if ($urandom_range(0, 3) != 0) add_cmd(CMD_STOP_PLAY);
  endfunction

  // One long recording that drives the position into saturation.
  function automatic void add_saturating_take();
    add_cmd(CMD_START_RECORD);
    repeat (1030) begin
      pending_words.push_back(word_of(CMD_TICK, NUM_SAMPLES_W'($urandom_range(16300, 16383)),
                                      LENGTH_W'($urandom())));
    end
    add_tick();
    add_tick();
    pending_words.push_back(word_of(CMD_SET_LENGTH, NUM_SAMPLES_W'($urandom()),
                                    LENGTH_W'($urandom_range(1, 5000))));
    add_tick();
    add_cmd(CMD_STOP_RECORD);
    repeat (5) add_tick();
    add_cmd(CMD_START_OVDB);
    add_tick();
    add_cmd(CMD_STOP_PLAY);
  endfunction

  // Sender: bursts of words with random gaps; predicts each accepted word.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      burst_left  = $urandom_range(1, 24);
      gap_left    = 0;
      trk_mode    = MODE_STOPPED;
      trk_pos     = '0;
      trk_len     = '0;
      trk_frac    = '0;
    end else begin
      word_fire = in_ch.valid && in_ch.ready;
      if (word_fire) begin
        want_report = transport_step(bus_word);
        expected_reports.push_back(bus_word.known ? bus_word.known_report : want_report);
      end
      if (!in_ch.valid || word_fire) begin
        if (gap_left > 0) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          bus_word = pending_words.pop_front();
          in_ch.valid        <= 1'b1;
          in_ch.cmd          <= bus_word.cmd;
          in_ch.num_samples  <= bus_word.num_samples;
          in_ch.length_value <= bus_word.length_value;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            case ($urandom_range(0, 3))
              0:       gap_left = 0;
              1:       gap_left = $urandom_range(20, 60);
              default: gap_left = $urandom_range(1, 10);
            endcase
          end else begin
            burst_left--;
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: ready follows one of four styles, redrawn at random whenever the phase counter wraps.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      rx_phase = 0;
      rx_style = 0;
    end else begin
      rx_phase++;
      if (rx_phase >= 250) begin
        rx_phase = 0;
        rx_style = $urandom_range(0, 3);
      end
      case (rx_style)
        0:       rx_ready = 1'b1;
        1:       rx_ready = 1'($urandom_range(0, 1));
        2:       rx_ready = (rx_phase % 7) >= 3;
        default: rx_ready = ($urandom_range(0, 9) != 0);
      endcase
      out_ch.ready <= rx_ready;
    end
  end

  // Checker: each accepted report against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n) begin
      report_fire = out_ch.valid && out_ch.ready;
      if (report_fire) begin
        got_report.mode        = mode_t'(out_ch.mode);
        got_report.position    = out_ch.position;
        got_report.loop_length = out_ch.loop_length;
        got_report.fraction    = out_ch.normalized_position;
        if (expected_reports.size() == 0) begin
          n_fail++;
          if (n_fail <= 10) begin
            $display("report %0d arrived with none pending: mode %0d position %0h",
                     n_reports, got_report.mode, got_report.position);
          end
        end else begin
          want_report = expected_reports.pop_front();
          if (got_report.mode != want_report.mode ||
              got_report.position != want_report.position ||
              got_report.loop_length != want_report.loop_length ||
              got_report.fraction != want_report.fraction) begin
            n_fail++;
            if (n_fail <= 10) begin
              $display("report %0d mismatch (expected/actual): mode %0d/%0d position %0h/%0h",
                       n_reports, want_report.mode, got_report.mode,
                       want_report.position, got_report.position);
              $display("  loop length %0h/%0h normalized position %0h/%0h",
                       want_report.loop_length, got_report.loop_length,
                       want_report.fraction, got_report.fraction);
            end
          end
        end
        n_reports++;
      end
    end
  end

  // Watchdog on cycles with no word moving on either channel.
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles = 0;
    end else begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Stimulus build, reset, drain and verdict.
  initial begin
    n_fail             = 0;
    n_reports          = 0;
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.cmd          = '0;
    in_ch.num_samples  = '0;
    in_ch.length_value = '0;
    out_ch.ready       = 1'b0;

    // Directed rows; a typed-in report is used where it is obvious.
    dir_rows = '{
      // Nothing moves while stopped and no loop exists.
      '{CMD_TICK,         14'd8192,  24'd0,      1'b1, '{MODE_STOPPED,   24'd0,    24'd0,   16'd0}},
      '{CMD_START_PLAY,   14'd0,     24'd0,      1'b1, '{MODE_STOPPED,   24'd0,    24'd0,   16'd0}},
      '{CMD_START_OVDB,   14'h3FFF,  24'hFFFFFF, 1'b1, '{MODE_STOPPED,   24'd0,    24'd0,   16'd0}},
      '{CMD_STOP_OVDB,    14'd0,     24'd0,      1'b1, '{MODE_STOPPED,   24'd0,    24'd0,   16'd0}},
      '{CMD_STOP_RECORD,  14'd0,     24'd0,      1'b1, '{MODE_STOPPED,   24'd0,    24'd0,   16'd0}},
      // An empty take returns to stopped.
      '{CMD_START_RECORD, 14'd0,     24'd0,      1'b1, '{MODE_RECORDING, 24'd0,    24'd0,   16'd0}},
      '{CMD_STOP_RECORD,  14'd0,     24'd0,      1'b1, '{MODE_STOPPED,   24'd0,    24'd0,   16'd0}},
      '{CMD_START_RECORD, 14'h3FFF,  24'hFFFFFF, 1'b1, '{MODE_RECORDING, 24'd0,    24'd0,   16'd0}},
      '{CMD_TICK,         14'd8192,  24'hFFFFFF, 1'b1, '{MODE_RECORDING, 24'd8192, 24'd0,   16'd0}},
      '{CMD_TICK,         14'd0,     24'd0,      1'b1, '{MODE_RECORDING, 24'd8192, 24'd0,   16'd0}},
      // Length below the position: fraction saturates on the next tick.
      '{CMD_SET_LENGTH,   14'h3FFF,  24'd100,    1'b1, '{MODE_RECORDING, 24'd8192, 24'd100, 16'd0}},
      '{CMD_TICK,         14'd1,     24'd0,      1'b1, '{MODE_RECORDING, 24'd8193, 24'd100, 16'hFFFF}},
      // Start play straight from recording keeps the position.
      '{CMD_START_PLAY,   14'd0,     24'd0,      1'b1, '{MODE_PLAYING,   24'd8193, 24'd100, 16'hFFFF}},
      '{CMD_TICK,         14'd0,     24'd0,      1'b0, '0},
      '{CMD_SET_LENGTH,   14'd0,     24'hFFFFFF, 1'b0, '0},
      '{CMD_TICK,         14'h3FFF,  24'd0,      1'b0, '0},
      '{CMD_START_OVDB,   14'd0,     24'd0,      1'b0, '0},
      '{CMD_TICK,         14'd8191,  24'd0,      1'b0, '0},
      '{CMD_STOP_OVDB,    14'd0,     24'd0,      1'b0, '0},
      '{CMD_STOP_PLAY,    14'h3FFF,  24'hFFFFFF, 1'b1, '{MODE_STOPPED,   24'd0,    24'hFFFFFF, 16'd0}},
      // A normal take becomes the loop and playback wraps to zero.
      '{CMD_START_RECORD, 14'd0,     24'd0,      1'b1, '{MODE_RECORDING, 24'd0,    24'd0,   16'd0}},
      '{CMD_TICK,         14'd5000,  24'd0,      1'b1, '{MODE_RECORDING, 24'd5000, 24'd0,   16'd0}},
      '{CMD_STOP_RECORD,  14'd0,     24'd0,      1'b1, '{MODE_PLAYING,   24'd0,    24'd5000, 16'd0}},
      '{CMD_TICK,         14'd4999,  24'd0,      1'b0, '0},
      '{CMD_TICK,         14'd1,     24'd0,      1'b1, '{MODE_PLAYING,   24'd0,    24'd5000, 16'd0}},
      // Clearing the length while playing stops the wrap.
      '{CMD_SET_LENGTH,   14'd0,     24'd0,      1'b1, '{MODE_PLAYING,   24'd0,    24'd0,   16'd0}},
      '{CMD_TICK,         14'd8192,  24'd0,      1'b1, '{MODE_PLAYING,   24'd8192, 24'd0,   16'd0}}
    };
    foreach (dir_rows[i]) pending_words.push_back(dir_rows[i]);

    // Random part: sessions, noise and one saturating take.
    begin : random_build
      bit took_long;
      took_long = 1'b0;
      while (pending_words.size() < N_DIRECTED + N_RANDOM) begin
        if (!took_long && pending_words.size() > N_DIRECTED + 300) begin
          add_saturating_take();
          took_long = 1'b1;
        end else if ($urandom_range(0, 9) < 7) begin
          add_session();
        end else begin
          repeat ($urandom_range(1, 6)) begin
            pending_words.push_back(word_of(cmd_t'($urandom_range(0, 7)),
                                            NUM_SAMPLES_W'($urandom()),
                                            LENGTH_W'($urandom())));
          end
        end
      end
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_words.size() != 0 || in_ch.valid || expected_reports.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (n_fail == 0 && expected_reports.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ sim.f @@
design/ltc_pkg.sv
design/ltc_if.sv
design/looper_transport_controller_core.sv
tb/tb_looper_transport_controller_core.sv
